// ===== rtl/rcc_pkg.sv =====
// Package: CRC-32 constants, request codes, transfer types and fold functions.
`timescale 1ns / 1ps
package rcc_pkg;

  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

  localparam logic [1:0] REQ_HEADER = 2'd0;
  localparam logic [1:0] REQ_CONT   = 2'd1;
  localparam logic [1:0] REQ_PLAIN  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam int FRONT_STAGES = 4;
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] crc;
    logic [31:0] value_length;
    logic [63:0] expiry_time;
    logic [7:0]  data_byte;
    logic        frame_end;
  } rcc_stage_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] crc;
    logic [7:0]  data_byte;
    logic        frame_end;
  } rcc_op_t;

  // one entry of the reflected CRC-32 byte table
  function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'h0, idx};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = CRC_POLY ^ (c >> 1);
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] fold_byte(input logic [31:0] crc, input logic [7:0] b);
    return crc_table_entry(crc[7:0] ^ b) ^ {8'h00, crc[31:8]};
  endfunction

  // four bytes, least significant first
  function automatic logic [31:0] fold_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc;
    c = fold_byte(c, w[7:0]);
    c = fold_byte(c, w[15:8]);
    c = fold_byte(c, w[23:16]);
    c = fold_byte(c, w[31:24]);
    return c;
  endfunction

endpackage

// ===== rtl/rcc_front.sv =====
// Front pipeline: classifies requests and folds the 17 header bytes over four stages.
`timescale 1ns / 1ps
module rcc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_rec_type,
  input  logic [31:0]         in_key_length,
  input  logic [31:0]         in_value_length,
  input  logic [63:0]         in_expiry_time,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_end,
  output logic                push,
  output rcc_pkg::rcc_op_t    push_op,
  input  logic                q_ready
);

  rcc_pkg::rcc_stage_t stg_r   [rcc_pkg::FRONT_STAGES];
  rcc_pkg::rcc_stage_t stg_nxt [rcc_pkg::FRONT_STAGES];
  logic                vld_r   [rcc_pkg::FRONT_STAGES];
  logic                en      [rcc_pkg::FRONT_STAGES];
  logic                vld0_nxt;

  always_comb begin
    en[rcc_pkg::FRONT_STAGES-1] = !vld_r[rcc_pkg::FRONT_STAGES-1] || q_ready;
    for (int i = rcc_pkg::FRONT_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];
  assign vld0_nxt = in_valid && (in_req_type != rcc_pkg::REQ_NONE);

  always_comb begin
    stg_nxt[0].kind         = in_req_type;
    stg_nxt[0].crc          = rcc_pkg::fold_word(
                                rcc_pkg::fold_byte(rcc_pkg::CRC_PRESET, in_rec_type),
                                in_key_length);
    stg_nxt[0].value_length = in_value_length;
    stg_nxt[0].expiry_time  = in_expiry_time;
    stg_nxt[0].data_byte    = in_data_byte;
    stg_nxt[0].frame_end    = in_frame_end;

    stg_nxt[1]     = stg_r[0];
    stg_nxt[1].crc = rcc_pkg::fold_word(stg_r[0].crc, stg_r[0].value_length);
    stg_nxt[2]     = stg_r[1];
    stg_nxt[2].crc = rcc_pkg::fold_word(stg_r[1].crc, stg_r[1].expiry_time[31:0]);
    stg_nxt[3]     = stg_r[2];
    stg_nxt[3].crc = rcc_pkg::fold_word(stg_r[2].crc, stg_r[2].expiry_time[63:32]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rcc_pkg::FRONT_STAGES; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld_r[0] <= vld0_nxt;
      end
      for (int i = 1; i < rcc_pkg::FRONT_STAGES; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rcc_pkg::FRONT_STAGES; i++) begin
      if (en[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign push              = vld_r[rcc_pkg::FRONT_STAGES-1] && q_ready;
  assign push_op.kind      = stg_r[rcc_pkg::FRONT_STAGES-1].kind;
  assign push_op.crc       = stg_r[rcc_pkg::FRONT_STAGES-1].crc;
  assign push_op.data_byte = stg_r[rcc_pkg::FRONT_STAGES-1].data_byte;
  assign push_op.frame_end = stg_r[rcc_pkg::FRONT_STAGES-1].frame_end;

endmodule

// ===== rtl/rcc_fifo.sv =====
// Short queue of classified operations between front and back.
`timescale 1ns / 1ps
module rcc_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  rcc_pkg::rcc_op_t          wdata,
  output logic                      ready,
  input  logic                      pop,
  output logic                      valid,
  output rcc_pkg::rcc_op_t          rdata,
  output logic [rcc_pkg::QCW-1:0]   count
);

  rcc_pkg::rcc_op_t               mem_r [rcc_pkg::QDEPTH];
  logic [rcc_pkg::QAW-1:0]        wptr_r, rptr_r;
  logic [rcc_pkg::QCW-1:0]        cnt_r;

  assign ready = cnt_r != rcc_pkg::QCW'(rcc_pkg::QDEPTH);
  assign valid = cnt_r != '0;
  assign rdata = mem_r[rptr_r];
  assign count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/rcc_back.sv =====
// Back end: running CRC update, frame-end inversion and output register.
`timescale 1ns / 1ps
module rcc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  rcc_pkg::rcc_op_t   op,
  output logic               op_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_checksum
);

  logic [31:0] running_r;
  logic [31:0] base;
  logic [31:0] crc_nxt;
  logic        out_valid_r;
  logic [31:0] checksum_r;

  assign op_pop = op_valid && (!op.frame_end || !out_valid_r || out_ready);

  always_comb begin
    base = (op.kind == rcc_pkg::REQ_CONT) ? running_r : rcc_pkg::CRC_PRESET;
    if (op.kind == rcc_pkg::REQ_HEADER) begin
      crc_nxt = op.crc;
    end else begin
      crc_nxt = rcc_pkg::fold_byte(base, op.data_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= rcc_pkg::CRC_PRESET;
      out_valid_r <= 1'b0;
    end else begin
      if (op_pop && op.frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (op_pop) begin
        if (op.frame_end) begin
          running_r <= rcc_pkg::CRC_PRESET;
        end else begin
          running_r <= crc_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && op.frame_end) begin
      checksum_r <= crc_nxt ^ rcc_pkg::CRC_XOROUT;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = checksum_r;

endmodule

// ===== rtl/record_crc32_checksum_top.sv =====
// Top level: CRC-32 over record and byte frames, front pipeline, queue and back end.
//
// Input channel (in_valid/in_ready) takes one request per transfer:
//   req_type 0 a record header (type, key length, value length, expiry time,
//   folded least significant byte first from a fresh preset), 1 a data byte
//   continuing the open frame, 2 a data byte starting a plain frame. Code 3
//   is dropped. frame_end on a transfer closes the frame.
// Output channel (out_valid/out_ready) carries one checksum per closed frame,
//   the inverted running CRC.
// Throughput: one request per cycle sustained, headers included, while no checksum
//   waits on out_ready; the header bytes fold across the four front stages and the
//   back end updates the running CRC with one byte-table fold per cycle.
// Path: the input transfer is registered through the four front stages, the queue
//   and the output register before the checksum shows on out_valid.
// Stall: while the output waits, requests without frame_end keep draining;
//   the four-entry queue and the front stages fill, then in_ready drops.
// Reset: running CRC preset to all ones, pipeline, queue and output emptied.
`timescale 1ns / 1ps
module record_crc32_checksum_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_req_type,
  input  logic [7:0]   in_rec_type,
  input  logic [31:0]  in_key_length,
  input  logic [31:0]  in_value_length,
  input  logic [63:0]  in_expiry_time,
  input  logic [7:0]   in_data_byte,
  input  logic         in_frame_end,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [31:0]  out_checksum
);

  logic                        q_push;
  rcc_pkg::rcc_op_t            q_wdata;
  logic                        q_ready;
  logic                        q_pop;
  logic                        q_valid;
  rcc_pkg::rcc_op_t            q_head;
  logic [rcc_pkg::QCW-1:0]     q_count;

  rcc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_rec_type     (in_rec_type),
    .in_key_length   (in_key_length),
    .in_value_length (in_value_length),
    .in_expiry_time  (in_expiry_time),
    .in_data_byte    (in_data_byte),
    .in_frame_end    (in_frame_end),
    .push            (q_push),
    .push_op         (q_wdata),
    .q_ready         (q_ready)
  );

  rcc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_head),
    .count (q_count)
  );

  rcc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_valid     (q_valid),
    .op           (q_head),
    .op_pop       (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_checksum (out_checksum)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> q_count != rcc_pkg::QCW'(rcc_pkg::QDEPTH))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_count != '0)
    else $error("queue read while empty");

  a_frame_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_head.frame_end |=> out_valid)
    else $error("frame end did not load the output register");

  a_no_result_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pending checksum lost");

endmodule

// ===== sim/record_crc32_checksum_checker.sv =====
// Checker: predicts CRC-32 frame checksums from input transfers and compares output transfers.
`timescale 1ns / 1ps
module record_crc32_checksum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_rec_type,
  input  logic [31:0] in_key_length,
  input  logic [31:0] in_value_length,
  input  logic [63:0] in_expiry_time,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_checksum,
  output int          fail_count,
  output int          sums_pending,
  output int          sums_checked
);

  logic [31:0] frame_crc;
  logic [31:0] sums_due[$];
  int          errs;
  int          seen;

  // bitwise reflected update, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ rcc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_le(input logic [31:0] crc, input logic [63:0] w,
                                         input int nbytes);
    logic [31:0] c;
    c = crc;
    for (int i = 0; i < nbytes; i++) begin
      c = crc_byte(c, w[8*i +: 8]);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    logic [31:0] next_crc;
    logic [31:0] want;
    if (!rst_n) begin
      frame_crc = rcc_pkg::CRC_PRESET;
      sums_due.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          errs++;
          $error("checksum: no transfer expected, actual %h", out_checksum);
        end else begin
          want = sums_due.pop_front();
          seen++;
          if (out_checksum !== want) begin
            errs++;
            $error("checksum: expected %h, actual %h", want, out_checksum);
          end
        end
      end
      if (in_valid && in_ready && in_req_type != rcc_pkg::REQ_NONE) begin
        case (in_req_type)
          rcc_pkg::REQ_HEADER: begin
            next_crc = crc_byte(rcc_pkg::CRC_PRESET, in_rec_type);
            next_crc = crc_le(next_crc, {32'h0, in_key_length}, 4);
            next_crc = crc_le(next_crc, {32'h0, in_value_length}, 4);
            next_crc = crc_le(next_crc, in_expiry_time, 8);
          end
          rcc_pkg::REQ_CONT: next_crc = crc_byte(frame_crc, in_data_byte);
          default: next_crc = crc_byte(rcc_pkg::CRC_PRESET, in_data_byte);
        endcase
        if (in_frame_end) begin
          sums_due.push_back(next_crc ^ rcc_pkg::CRC_XOROUT);
          frame_crc = rcc_pkg::CRC_PRESET;
        end else begin
          frame_crc = next_crc;
        end
      end
    end
    fail_count   <= errs;
    sums_pending <= sums_due.size();
    sums_checked <= seen;
  end

endmodule

// ===== sim/record_crc32_checksum_top_tb.sv =====
// Testbench top: drives record and byte frames with random idling and gives the verdict.
`timescale 1ns / 1ps
module record_crc32_checksum_top_tb;

  localparam int N_RANDOM = 1550;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_req_type;
  logic [7:0]  in_rec_type;
  logic [31:0] in_key_length;
  logic [31:0] in_value_length;
  logic [63:0] in_expiry_time;
  logic [7:0]  in_data_byte;
  logic        in_frame_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_checksum;

  int fail_count;
  int sums_pending;
  int sums_checked;
  int n_sent;
  int n_ignored;
  int n_headers;
  bit quiet_in;

  record_crc32_checksum_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_rec_type     (in_rec_type),
    .in_key_length   (in_key_length),
    .in_value_length (in_value_length),
    .in_expiry_time  (in_expiry_time),
    .in_data_byte    (in_data_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum    (out_checksum)
  );

  record_crc32_checksum_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_rec_type     (in_rec_type),
    .in_key_length   (in_key_length),
    .in_value_length (in_value_length),
    .in_expiry_time  (in_expiry_time),
    .in_data_byte    (in_data_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_checksum    (out_checksum),
    .fail_count      (fail_count),
    .sums_pending    (sums_pending),
    .sums_checked    (sums_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(input logic [1:0] req, input logic [7:0] rec, input logic [31:0] kl,
                          input logic [31:0] vl, input logic [63:0] et, input logic [7:0] db,
                          input logic fe);
    int gap;
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_rec_type     <= rec;
    in_key_length   <= kl;
    in_value_length <= vl;
    in_expiry_time  <= et;
    in_data_byte    <= db;
    in_frame_end    <= fe;
    do @(posedge clk); while (!in_ready);
    if (req == rcc_pkg::REQ_NONE) n_ignored++;
    else n_sent++;
    if (req == rcc_pkg::REQ_HEADER) n_headers++;
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_rand(input logic [1:0] req, input logic fe);
    push_req(req, 8'($urandom), $urandom, $urandom, rand64(), 8'($urandom), fe);
  endtask

  // well-formed frame: opener, then continue bytes, end flag on the last transfer
  task automatic push_frame(input logic [1:0] opener);
    int extra;
    extra = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
    push_rand(opener, extra == 0);
    for (int i = extra; i > 0; i--) begin
      if ($urandom_range(0, 19) == 0) push_rand(rcc_pkg::REQ_NONE, 1'($urandom));
      push_rand(rcc_pkg::REQ_CONT, i == 1);
    end
  endtask

  task automatic wait_all_sums();
    in_valid <= 1'b0;
    do @(posedge clk); while (sums_pending != 0);
  endtask

  initial begin
    int target;
    int pick;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_req_type     <= rcc_pkg::REQ_NONE;
    in_rec_type     <= '0;
    in_key_length   <= '0;
    in_value_length <= '0;
    in_expiry_time  <= '0;
    in_data_byte    <= '0;
    in_frame_end    <= 1'b0;
    quiet_in = 1'b0;
    n_sent = 0;
    n_ignored = 0;
    n_headers = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // header extremes, plain byte extremes
    push_req(rcc_pkg::REQ_HEADER, 8'h00, 32'h0, 32'h0, 64'h0, 8'hFF, 1'b1);
    push_req(rcc_pkg::REQ_HEADER, 8'hFF, '1, '1, '1, 8'h00, 1'b1);
    push_req(rcc_pkg::REQ_PLAIN, 8'hFF, '1, '1, '1, 8'h00, 1'b1);
    push_req(rcc_pkg::REQ_PLAIN, 8'h00, 32'h0, 32'h0, 64'h0, 8'hFF, 1'b1);
    // continue with no open frame
    push_req(rcc_pkg::REQ_CONT, 8'h5A, '1, 32'h0, '1, 8'hA5, 1'b0);
    push_req(rcc_pkg::REQ_CONT, 8'h00, 32'h0, '1, 64'h0, 8'h3C, 1'b1);
    // dropped code inside an open frame, end flag ignored
    push_rand(rcc_pkg::REQ_HEADER, 1'b0);
    push_req(rcc_pkg::REQ_NONE, 8'hFF, '1, '1, '1, 8'hFF, 1'b1);
    push_req(rcc_pkg::REQ_NONE, 8'h00, 32'h0, 32'h0, 64'h0, 8'h00, 1'b0);
    push_req(rcc_pkg::REQ_CONT, 8'hFF, '1, '1, '1, 8'h00, 1'b1);
    // "123456789" as a plain frame
    push_req(rcc_pkg::REQ_PLAIN, 8'h00, 32'h0, 32'h0, 64'h0, 8'h31, 1'b0);
    for (int c = 8'h32; c <= 8'h39; c++) begin
      push_req(rcc_pkg::REQ_CONT, 8'h00, 32'h0, 32'h0, 64'h0, c[7:0], c == 8'h39);
    end
    // restarts in the middle of a frame
    push_rand(rcc_pkg::REQ_PLAIN, 1'b0);
    push_rand(rcc_pkg::REQ_HEADER, 1'b0);
    push_rand(rcc_pkg::REQ_CONT, 1'b1);
    push_rand(rcc_pkg::REQ_HEADER, 1'b0);
    push_rand(rcc_pkg::REQ_PLAIN, 1'b1);
    push_rand(rcc_pkg::REQ_CONT, 1'b1);
    wait_all_sums();

    target = n_sent + N_RANDOM;
    while (n_sent < target) begin
      if ($urandom_range(0, 29) == 0) quiet_in = !quiet_in;
      pick = $urandom_range(0, 99);
      if (pick < 45) push_frame(rcc_pkg::REQ_HEADER);
      else if (pick < 80) push_frame(rcc_pkg::REQ_PLAIN);
      else if (pick < 85) push_rand(rcc_pkg::REQ_NONE, 1'($urandom));
      else push_rand(2'($urandom_range(0, 2)), 1'($urandom));
      if ($urandom_range(0, 199) == 0) wait_all_sums();
    end

    wait_all_sums();
    repeat (20) @(posedge clk);
    $display("covered %0d requests (%0d record headers) and %0d dropped code-3 requests",
             n_sent, n_headers, n_ignored);
    $display("compared %0d frame checksums", sums_checked);
    if (fail_count == 0 && sums_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int  ready_len;
    int  stall_len;
    bit  quiet_out;
    out_ready <= 1'b0;
    quiet_out = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
      ready_len = $urandom_range(1, quiet_out ? 60 : 6);
      stall_len = quiet_out ? 0 : pick_gap(1'b0);
      out_ready <= 1'b1;
      repeat (ready_len) @(posedge clk);
      if (stall_len > 0) begin
        out_ready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

endmodule
